// ===== rtl/shared_array_dual_stack_unit_assert.svh =====
// Assertion macros for the shared array dual stack unit.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef SHARED_ARRAY_DUAL_STACK_UNIT_ASSERT_SVH
`define SHARED_ARRAY_DUAL_STACK_UNIT_ASSERT_SVH

// same-cycle implication
`define SADS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SADS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sads_pkg.sv =====
// Shared types and constants for the shared array dual stack unit.
// No dependencies.
package sads_pkg;

	localparam int SADS_STORE_DEPTH = 128;
	localparam int SADS_DATA_W      = 32;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} sads_status_t;

	typedef enum logic {
		FN_PUSH = 1'b0,
		FN_POP  = 1'b1
	} sads_func_t;

	// result of one transaction, registered in the control block
	typedef struct packed {
		logic         valid;
		logic         pop_ok;
		sads_status_t status;
	} sads_res_t;

endpackage

// ===== rtl/sads_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module sads_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/sads_ctrl.sv =====
// Stack pointer control: occupancy counts, full/empty checks, RAM addressing.
// Depends on sads_pkg.
module sads_ctrl import sads_pkg::*; #(
	parameter int STORE_DEPTH = SADS_STORE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic                           func,
	input  logic                           stack_sel,
	input  logic [SADS_DATA_W-1:0]         push_value,
	output logic                           mem_we,
	output logic                           mem_re,
	output logic [$clog2(STORE_DEPTH)-1:0] mem_addr,
	output logic [SADS_DATA_W-1:0]         mem_wdata,
	output sads_res_t                      res_s1
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	logic [CW-1:0] lower_q;
	logic [CW-1:0] upper_q;
	logic [CW:0]   used;
	logic          full;
	logic          is_pop;
	logic          sel_empty;
	logic          push_ok;
	logic          pop_ok;
	logic [CW-1:0] push_idx;
	logic [CW-1:0] pop_idx;

	assign is_pop    = (func == FN_POP);
	assign used      = {1'b0, lower_q} + {1'b0, upper_q};
	assign full      = (used >= {1'b0, DEPTH_C});
	assign sel_empty = stack_sel ? (upper_q == '0) : (lower_q == '0);
	assign push_ok   = accept && !is_pop && !full;
	assign pop_ok    = accept && is_pop && !sel_empty;

	// stack 1 sits at the top of the store and grows down
	assign push_idx = stack_sel ? (DEPTH_C - ONE_C - upper_q) : lower_q;
	assign pop_idx  = stack_sel ? (DEPTH_C - upper_q) : (lower_q - ONE_C);

	// A push is written at the end of its cycle, so a pop in the next cycle
	// already reads the new word; no forwarding needed.
	assign mem_we    = push_ok;
	assign mem_re    = pop_ok;
	assign mem_addr  = is_pop ? pop_idx[AW-1:0] : push_idx[AW-1:0];
	assign mem_wdata = push_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
			res_s1  <= '{valid: 1'b0, pop_ok: 1'b0, status: ST_OK};
		end else begin
			if (push_ok) begin
				if (stack_sel) upper_q <= upper_q + ONE_C;
				else           lower_q <= lower_q + ONE_C;
			end else if (pop_ok) begin
				if (stack_sel) upper_q <= upper_q - ONE_C;
				else           lower_q <= lower_q - ONE_C;
			end
			res_s1.valid  <= accept;
			res_s1.pop_ok <= pop_ok;
			if (!is_pop && full)           res_s1.status <= ST_FULL;
			else if (is_pop && sel_empty)  res_s1.status <= ST_EMPTY;
			else                           res_s1.status <= ST_OK;
		end
	end

endmodule

// ===== rtl/shared_array_dual_stack_unit.sv =====
// Top level of the shared array dual stack unit: control plus word store.
// Depends on sads_pkg, sads_ctrl, sads_ram and the assertion macro header.
`include "shared_array_dual_stack_unit_assert.svh"

// Two stacks share one word store of STORE_DEPTH entries; stack 0 grows up
// from entry 0, stack 1 grows down from the last entry. A transaction is taken
// when start is high and busy is low, and one can be taken every cycle. Its
// result (status, pop_data) appears with done high in the cycle right after
// acceptance, for that one cycle only, pop_data from the store's read register
// and status from the control block's result register; the receiver cannot
// stall it. busy is high during reset and in the first cycle after it.
module shared_array_dual_stack_unit import sads_pkg::*; #(
	parameter int STORE_DEPTH = SADS_STORE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   func,
	input  logic                   stack_sel,
	input  logic [SADS_DATA_W-1:0] push_value,
	output logic                   done,
	output logic [1:0]             status,
	output logic [SADS_DATA_W-1:0] pop_data
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic                   busy_q;
	logic                   accept;
	logic                   mem_we;
	logic                   mem_re;
	logic [AW-1:0]          mem_addr;
	logic [SADS_DATA_W-1:0] mem_wdata;
	logic [SADS_DATA_W-1:0] mem_rdata;
	sads_res_t              res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	sads_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (func),
		.stack_sel (stack_sel),
		.push_value(push_value),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.res_s1    (res_s1)
	);

	sads_ram #(
		.WIDTH(SADS_DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign done     = res_s1.valid;
	assign status   = res_s1.status;
	assign pop_data = (res_s1.valid && res_s1.pop_ok) ? mem_rdata : '0;

	`SADS_ASSERT_NXT(a_done_after_accept, clk, arst_n, accept, done, "missing result strobe")
	`SADS_ASSERT_NXT(a_no_spurious_done, clk, arst_n, !accept, !done, "result without transaction")
	`SADS_ASSERT_IMP(a_fail_no_data, clk, arst_n, done && (status != ST_OK), pop_data == '0, "data on failed transaction")
	`SADS_ASSERT_IMP(a_empty_only_pop, clk, arst_n, done && (status == ST_EMPTY), $past(func) == FN_POP, "empty status on push")

endmodule

// ===== tb/shared_array_dual_stack_unit_test.sv =====
// Self-checking testbench for shared_array_dual_stack_unit: directed and random push/pop traffic.
// Depends on sads_pkg and the shared_array_dual_stack_unit RTL; needs nothing else.
`timescale 1ns / 100ps

module shared_array_dual_stack_unit_test;
	import sads_pkg::*;

	localparam int   CYCLE_LIMIT = 200000;
	localparam logic STK_LOW     = 1'b0; // grows up from entry 0
	localparam logic STK_HIGH    = 1'b1; // grows down from the last entry

	typedef struct {
		sads_status_t           status;
		logic [SADS_DATA_W-1:0] pop_data;
	} stack_reply_t;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   start      = 1'b0;
	logic                   func       = FN_PUSH;
	logic                   stack_sel  = STK_LOW;
	logic [SADS_DATA_W-1:0] push_value = '0;
	logic                   busy;
	logic                   done;
	logic [1:0]             status;
	logic [SADS_DATA_W-1:0] pop_data;

	// mirror of the block's state
	logic [SADS_DATA_W-1:0] word_mirror [SADS_STORE_DEPTH];
	int                     lower_cnt = 0;
	int                     upper_cnt = 0;

	stack_reply_t           expected_replies [$];
	int                     fail_cnt   = 0;
	int                     cycle_cnt  = 0;
	bit                     gaps_on    = 1'b1;
	int                     push_cnt   = 0;
	int                     refused_cnt = 0;
	int                     pop_cnt    = 0;
	int                     empty_cnt  = 0;
	int                     peak_fill  = 0;

	shared_array_dual_stack_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.stack_sel  (stack_sel),
		.push_value (push_value),
		.done       (done),
		.status     (status),
		.pop_data   (pop_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic stack_reply_t stack_op_predict(input sads_func_t fn, input logic sel,
			input logic [SADS_DATA_W-1:0] val);
		stack_reply_t r;
		r.status   = ST_OK;
		r.pop_data = '0;
		if (fn == FN_PUSH) begin
			push_cnt++;
			if (lower_cnt + upper_cnt >= SADS_STORE_DEPTH) begin
				r.status = ST_FULL;
				refused_cnt++;
			end else if (sel == STK_LOW) begin
				word_mirror[lower_cnt] = val;
				lower_cnt++;
			end else begin
				word_mirror[SADS_STORE_DEPTH - 1 - upper_cnt] = val;
				upper_cnt++;
			end
			if (lower_cnt + upper_cnt > peak_fill)
				peak_fill = lower_cnt + upper_cnt;
		end else begin
			pop_cnt++;
			if (sel == STK_LOW) begin
				if (lower_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					lower_cnt--;
					r.pop_data = word_mirror[lower_cnt];
				end
			end else begin
				if (upper_cnt == 0) begin
					r.status = ST_EMPTY;
				end else begin
					upper_cnt--;
					r.pop_data = word_mirror[SADS_STORE_DEPTH - 1 - upper_cnt];
				end
			end
			if (r.status == ST_EMPTY)
				empty_cnt++;
		end
		return r;
	endfunction

	// result checker: done is a one-cycle strobe, sampled at the edge that ends it
	always @(posedge clk) begin
		stack_reply_t exp;
		if (arst_n && done) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected result: status %0d pop_data %h", status, pop_data);
				fail_cnt++;
			end else begin
				exp = expected_replies.pop_front();
				if (status !== exp.status) begin
					$error("status: expected %0d, actual %0d", exp.status, status);
					fail_cnt++;
				end
				if (pop_data !== exp.pop_data) begin
					$error("pop_data: expected %h, actual %h", exp.pop_data, pop_data);
					fail_cnt++;
				end
			end
		end
	end

	// call at a rising edge; returns at a rising edge
	task automatic send_op(input sads_func_t fn, input logic sel, input logic [SADS_DATA_W-1:0] val);
		int gap;
		start      <= 1'b1;
		func       <= fn;
		stack_sel  <= sel;
		push_value <= val;
		do @(posedge clk); while (busy);
		expected_replies.push_back(stack_op_predict(fn, sel, val));
		gap = gaps_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off new transactions until every outstanding result is back
	task automatic wait_for_replies();
		start <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [SADS_DATA_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_ops(input int n, input int push_pct);
		sads_func_t fn;
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			fn = ($urandom_range(0, 99) < push_pct) ? FN_PUSH : FN_POP;
			send_op(fn, 1'($urandom_range(0, 1)), pick_word());
		end
	endtask

	task automatic test_empty_pops();
		send_op(FN_POP, STK_LOW, 32'hdead_beef);
		send_op(FN_POP, STK_HIGH, 32'h1234_5678);
	endtask

	task automatic test_word_extremes();
		send_op(FN_PUSH, STK_LOW, 32'h8000_0000);
		send_op(FN_PUSH, STK_HIGH, 32'h7fff_ffff);
		send_op(FN_PUSH, STK_LOW, 32'hffff_ffff);
		send_op(FN_PUSH, STK_HIGH, 32'h0000_0000);
		send_op(FN_PUSH, STK_LOW, 32'h0000_0001);
		send_op(FN_POP, STK_HIGH, $urandom());
		send_op(FN_POP, STK_HIGH, $urandom());
		send_op(FN_POP, STK_HIGH, $urandom());
		send_op(FN_POP, STK_LOW, $urandom());
		send_op(FN_POP, STK_LOW, $urandom());
		send_op(FN_POP, STK_LOW, $urandom());
		send_op(FN_POP, STK_LOW, $urandom());
	endtask

	// push then pop the same entry on consecutive cycles, then interleave both stacks: read right after write
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		send_op(FN_PUSH, STK_HIGH, 32'ha5a5_5a5a);
		send_op(FN_POP, STK_HIGH, 32'h0);
		send_op(FN_PUSH, STK_LOW, 32'h5a5a_a5a5);
		send_op(FN_POP, STK_LOW, 32'h0);
		send_op(FN_PUSH, STK_LOW, 32'h0f0f_f0f0);
		send_op(FN_PUSH, STK_HIGH, 32'hf0f0_0f0f);
		send_op(FN_POP, STK_LOW, 32'h0);
		send_op(FN_POP, STK_HIGH, 32'h0);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_mixed(input int n);
		random_ops(n, 50);
	endtask

	// push-heavy traffic runs into the full store and refused pushes
	task automatic test_fill_to_overflow();
		random_ops(450, 85);
	endtask

	task automatic test_drain_to_empty();
		random_ops(300, 20);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_word_extremes();
		test_back_to_back();
		wait_for_replies();
		test_random_mixed(400);
		test_fill_to_overflow();
		wait_for_replies();
		test_drain_to_empty();
		test_random_mixed(250);

		wait_for_replies();
		repeat (4) @(posedge clk);
		if (expected_replies.size() != 0) begin
			$error("%0d results never arrived", expected_replies.size());
			fail_cnt++;
		end
		$display("run covered %0d pushes (%0d refused, store full) and %0d pops (%0d empty)",
			push_cnt, refused_cnt, pop_cnt, empty_cnt);
		$display("highest combined fill reached: %0d of %0d entries", peak_fill, SADS_STORE_DEPTH);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
